/* sv/scancode_to_key_matrix_top_assert.svh */
// Assertion macros for the RTL file that carries checks, sckm_matrix.sv.
`ifndef SCANCODE_TO_KEY_MATRIX_TOP_ASSERT_SVH
`define SCANCODE_TO_KEY_MATRIX_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

`define SCKM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define SCKM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SCKM_ASSERT(lbl, clk, rst, prop, msg)

`define SCKM_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* sv/sckm_pkg.sv */
package sckm_pkg;

  localparam int ROW_IDX_W = 4;
  localparam int CODE_W = 8;
  localparam int ROW_W = 8;
  localparam int HOT_W = 4;
  localparam int DEFAULT_MATRIX_ROWS = 16;

  localparam logic [CODE_W-1:0] CODE_PREFIX_EXT = 8'hE0;
  localparam logic [CODE_W-1:0] CODE_EXIT       = 8'hCF;
  localparam logic [CODE_W-1:0] CODE_LINE_UP    = 8'h49;
  localparam logic [CODE_W-1:0] CODE_LINE_DOWN  = 8'h51;
  localparam logic [CODE_W-1:0] CODE_REFRESH    = 8'h42;
  localparam logic [CODE_W-1:0] CODE_DISK_B     = 8'h41;
  localparam logic [CODE_W-1:0] CODE_DISK_A     = 8'h40;
  localparam logic [CODE_W-1:0] CODE_TRACE      = 8'h43;
  localparam logic [CODE_W-1:0] CODE_QUIET      = 8'h44;

  localparam logic [HOT_W-1:0] HOT_NONE      = 4'd0;
  localparam logic [HOT_W-1:0] HOT_EXIT      = 4'd1;
  localparam logic [HOT_W-1:0] HOT_LINE_UP   = 4'd2;
  localparam logic [HOT_W-1:0] HOT_LINE_DOWN = 4'd3;
  localparam logic [HOT_W-1:0] HOT_REFRESH   = 4'd4;
  localparam logic [HOT_W-1:0] HOT_DISK_B    = 4'd5;
  localparam logic [HOT_W-1:0] HOT_DISK_A    = 4'd6;
  localparam logic [HOT_W-1:0] HOT_TRACE     = 4'd7;
  localparam logic [HOT_W-1:0] HOT_QUIET     = 4'd8;

  localparam logic REQ_SCAN = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic                 is_read;
    logic                 is_prefix;
    logic                 is_lookup;
    logic                 is_release;
    logic [HOT_W-1:0]     hotkey;
    logic [ROW_IDX_W-1:0] row;
    logic [ROW_W-1:0]     mask;
  } dec_t;

  typedef struct packed {
    logic [ROW_IDX_W-1:0] row_index;
    logic [ROW_W-1:0]     row_value;
    logic                 row_changed;
    logic [HOT_W-1:0]     hotkey;
  } res_t;

  // Entry is row in the upper byte and key mask in the lower byte. Index bit 7
  // is the extended flag, the rest the low seven bits of the scan code.
  function automatic logic [15:0] key_entry(input logic [CODE_W-1:0] idx);
    logic [15:0] e;
    begin
      unique case (idx)
        8'h01: e = 16'h0704;  8'h02: e = 16'h0002;  8'h03: e = 16'h0004;
        8'h04: e = 16'h0008;  8'h05: e = 16'h0010;  8'h06: e = 16'h0020;
        8'h07: e = 16'h0040;  8'h08: e = 16'h0080;  8'h09: e = 16'h0101;
        8'h0A: e = 16'h0102;  8'h0B: e = 16'h0001;  8'h0C: e = 16'h0104;
        8'h0D: e = 16'h0108;  8'h0E: e = 16'h0720;  8'h0F: e = 16'h0708;
        8'h10: e = 16'h0440;  8'h11: e = 16'h0510;  8'h12: e = 16'h0304;
        8'h13: e = 16'h0480;  8'h14: e = 16'h0502;  8'h15: e = 16'h0540;
        8'h16: e = 16'h0504;  8'h17: e = 16'h0340;  8'h18: e = 16'h0410;
        8'h19: e = 16'h0420;  8'h1A: e = 16'h0120;  8'h1B: e = 16'h0140;
        8'h1C: e = 16'h0780;  8'h1D: e = 16'h0602;  8'h1E: e = 16'h0240;
        8'h1F: e = 16'h0501;  8'h20: e = 16'h0302;  8'h21: e = 16'h0308;
        8'h22: e = 16'h0310;  8'h23: e = 16'h0320;  8'h24: e = 16'h0380;
        8'h25: e = 16'h0401;  8'h26: e = 16'h0402;  8'h27: e = 16'h0180;
        8'h28: e = 16'h0201;  8'h29: e = 16'h0704;  8'h2A: e = 16'h0601;
        8'h2B: e = 16'h0202;  8'h2C: e = 16'h0580;  8'h2D: e = 16'h0520;
        8'h2E: e = 16'h0301;  8'h2F: e = 16'h0508;  8'h30: e = 16'h0280;
        8'h31: e = 16'h0408;  8'h32: e = 16'h0404;  8'h33: e = 16'h0204;
        8'h34: e = 16'h0208;  8'h35: e = 16'h0210;  8'h36: e = 16'h0601;
        8'h37: e = 16'h0901;  8'h38: e = 16'h0604;  8'h39: e = 16'h0801;
        8'h3A: e = 16'h0608;  8'h3B: e = 16'h0620;  8'h3C: e = 16'h0640;
        8'h3D: e = 16'h0680;  8'h3E: e = 16'h0701;  8'h3F: e = 16'h0702;
        8'h47: e = 16'h0A04;  8'h48: e = 16'h0A08;  8'h49: e = 16'h0A10;
        8'h4A: e = 16'h0A20;  8'h4B: e = 16'h0980;  8'h4C: e = 16'h0A01;
        8'h4D: e = 16'h0A02;  8'h4E: e = 16'h0902;  8'h4F: e = 16'h0910;
        8'h50: e = 16'h0920;  8'h51: e = 16'h0940;  8'h52: e = 16'h0908;
        8'h53: e = 16'h0A80;  8'h57: e = 16'h0740;  8'h58: e = 16'h0710;
        8'h70: e = 16'h0610;  8'h73: e = 16'h0220;  8'h7D: e = 16'h0110;
        8'h9C: e = 16'h0780;  8'h9D: e = 16'h0610;  8'hB5: e = 16'h0210;
        8'hB8: e = 16'h0740;  8'hBA: e = 16'h0608;  8'hC7: e = 16'h0802;
        8'hC8: e = 16'h0820;  8'hCB: e = 16'h0810;  8'hCD: e = 16'h0880;
        8'hD0: e = 16'h0840;  8'hD2: e = 16'h0804;  8'hD3: e = 16'h0808;
        8'hF0: e = 16'h0610;
        default: e = 16'h0000;
      endcase
      return e;
    end
  endfunction

endpackage

/* sv/sckm_in_if.sv */
interface sckm_in_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic [sckm_pkg::CODE_W-1:0]         scan_code;
  logic [sckm_pkg::ROW_IDX_W-1:0]      row_select;

  modport source(output valid, req_type, scan_code, row_select, input ready);
  modport sink(input valid, req_type, scan_code, row_select, output ready);
endinterface

/* sv/sckm_out_if.sv */
interface sckm_out_if;
  logic                                valid;
  logic                                ready;
  logic [sckm_pkg::ROW_IDX_W-1:0]      row_index;
  logic [sckm_pkg::ROW_W-1:0]          row_value;
  logic                                row_changed;
  logic [sckm_pkg::HOT_W-1:0]          hotkey;

  modport source(output valid, row_index, row_value, row_changed, hotkey, input ready);
  modport sink(input valid, row_index, row_value, row_changed, hotkey, output ready);
endinterface

/* sv/sckm_decode.sv */
module sckm_decode (
  input  logic                              req_type,
  input  logic [sckm_pkg::CODE_W-1:0]       scan_code,
  input  logic                              ext_pending,
  output sckm_pkg::dec_t                    dec
);

  logic [sckm_pkg::HOT_W-1:0] hot;
  logic [15:0]                entry;
  logic                       is_read;
  logic                       is_prefix;

  always_comb begin
    hot = sckm_pkg::HOT_NONE;
    if (ext_pending && scan_code == sckm_pkg::CODE_EXIT) begin
      hot = sckm_pkg::HOT_EXIT;
    end else if (ext_pending && scan_code == sckm_pkg::CODE_LINE_UP) begin
      hot = sckm_pkg::HOT_LINE_UP;
    end else if (ext_pending && scan_code == sckm_pkg::CODE_LINE_DOWN) begin
      hot = sckm_pkg::HOT_LINE_DOWN;
    end else if (scan_code == sckm_pkg::CODE_REFRESH) begin
      hot = sckm_pkg::HOT_REFRESH;
    end else if (scan_code == sckm_pkg::CODE_DISK_B) begin
      hot = sckm_pkg::HOT_DISK_B;
    end else if (scan_code == sckm_pkg::CODE_DISK_A) begin
      hot = sckm_pkg::HOT_DISK_A;
    end else if (scan_code == sckm_pkg::CODE_TRACE) begin
      hot = sckm_pkg::HOT_TRACE;
    end else if (scan_code == sckm_pkg::CODE_QUIET) begin
      hot = sckm_pkg::HOT_QUIET;
    end
  end

  assign is_read   = (req_type == sckm_pkg::REQ_READ);
  assign is_prefix = !is_read && (scan_code == sckm_pkg::CODE_PREFIX_EXT);
  assign entry     = sckm_pkg::key_entry({ext_pending, scan_code[6:0]});

  always_comb begin
    dec.is_read    = is_read;
    dec.is_prefix  = is_prefix;
    dec.hotkey     = (is_read || is_prefix) ? sckm_pkg::HOT_NONE : hot;
    dec.is_lookup  = !is_read && !is_prefix && (hot == sckm_pkg::HOT_NONE);
    dec.is_release = scan_code[7];
    dec.row        = entry[8 +: sckm_pkg::ROW_IDX_W];
    dec.mask       = entry[7:0];
  end

endmodule

/* sv/sckm_matrix.sv */
`include "scancode_to_key_matrix_top_assert.svh"

module sckm_matrix #(
  parameter int MATRIX_ROWS = sckm_pkg::DEFAULT_MATRIX_ROWS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              update,
  input  logic [sckm_pkg::ROW_IDX_W-1:0]    row_select,
  input  sckm_pkg::dec_t                    dec,
  output logic                              ext_pending,
  output sckm_pkg::res_t                    res
);

  localparam int IDX_W = $clog2(MATRIX_ROWS);
  localparam logic [sckm_pkg::ROW_IDX_W:0] ROWS_LIMIT =
    (sckm_pkg::ROW_IDX_W + 1)'(MATRIX_ROWS);

  logic [sckm_pkg::ROW_W-1:0]     key_matrix [MATRIX_ROWS];
  logic [sckm_pkg::ROW_IDX_W-1:0] row_addr;
  logic                           in_range;
  logic [sckm_pkg::ROW_W-1:0]     row_cur;
  logic [sckm_pkg::ROW_W-1:0]     row_next;
  logic                           row_write;

  assign row_addr  = dec.is_read ? row_select : dec.row;
  assign in_range  = {1'b0, row_addr} < ROWS_LIMIT;
  assign row_cur   = in_range ? key_matrix[row_addr[IDX_W-1:0]] : 8'hFF;
  assign row_next  = dec.is_release ? (row_cur | dec.mask) : (row_cur & ~dec.mask);
  assign row_write = dec.is_lookup && in_range;

  always_comb begin
    res = '0;
    if (dec.is_read) begin
      res.row_index = row_select;
      res.row_value = row_cur;
    end else if (dec.is_lookup) begin
      res.row_index   = dec.row;
      res.row_value   = in_range ? row_next : 8'hFF;
      res.row_changed = in_range;
    end else begin
      res.hotkey = dec.hotkey;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MATRIX_ROWS; i++) begin
        key_matrix[i] <= 8'hFF;
      end
      ext_pending <= 1'b0;
    end else if (update) begin
      if (row_write) begin
        key_matrix[row_addr[IDX_W-1:0]] <= row_next;
      end
      if (dec.is_prefix) begin
        ext_pending <= 1'b1;
      end else if (dec.is_lookup) begin
        ext_pending <= 1'b0;
      end
    end
  end

  `SCKM_ASSERT(a_prefix_arms, clk, rst, (update && dec.is_prefix) |=> ext_pending, "prefix did not arm extended flag")
  `SCKM_ASSERT(a_lookup_clears, clk, rst, (update && dec.is_lookup) |=> !ext_pending, "lookup left extended flag armed")
  `SCKM_ASSERT(a_flag_kept, clk, rst, (update && (dec.is_read || dec.hotkey != sckm_pkg::HOT_NONE)) |=> $stable(ext_pending), "read or hotkey changed extended flag")
  `SCKM_ASSERT(a_press_clears, clk, rst, (update && row_write && !dec.is_release) |=> (key_matrix[$past(row_addr[IDX_W-1:0])] & $past(dec.mask)) == '0, "pressed key bits not cleared")
  `SCKM_ASSERT_ALWAYS(a_changed_only_lookup, clk, res.row_changed |-> (dec.is_lookup && res.hotkey == sckm_pkg::HOT_NONE), "row change flagged outside a lookup")

endmodule

/* sv/scancode_to_key_matrix_top.sv */
// Scan code to key matrix converter.
// The request channel carries one word per item: req_type 0 delivers a set 1
// scan code byte, req_type 1 asks for one row of the key matrix. The result
// channel returns exactly one word per request with the row touched, its
// active-low contents, whether a table lookup wrote it, and a hotkey code.
// An E0 byte only arms the extended flag; hotkeys are reported and change
// nothing else.
// A word accepted into the input register is decoded there, applied to the
// matrix as it moves into the result register, and is valid on the result
// channel from then on. One word is taken every cycle while the result
// receiver keeps up; the single table lookup and row update between the
// input and result registers set that rate. When the result receiver
// stalls, the result register holds its word and the input register keeps
// one more; request ready falls only when both are full or reset is held.
// Reset sets every matrix bit to one, clears the extended flag and empties
// both registers.
module scancode_to_key_matrix_top #(
  parameter int MATRIX_ROWS = sckm_pkg::DEFAULT_MATRIX_ROWS
) (
  input logic        clk,
  input logic        rst,
  sckm_in_if.sink    request,
  sckm_out_if.source result
);

  logic                             stage_valid;
  logic                             stage_req;
  logic [sckm_pkg::CODE_W-1:0]      stage_code;
  logic [sckm_pkg::ROW_IDX_W-1:0]   stage_sel;
  logic                             res_valid;
  sckm_pkg::res_t                   res_word;
  sckm_pkg::res_t                   res_next;
  sckm_pkg::dec_t                   dec;
  logic                             ext_pending;
  logic                             advance;

  assign advance       = stage_valid && (!res_valid || result.ready);
  // No word is taken while reset is held.
  assign request.ready = !rst && (!stage_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (request.ready) begin
      stage_valid <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      stage_req  <= request.req_type;
      stage_code <= request.scan_code;
      stage_sel  <= request.row_select;
    end
  end

  sckm_decode u_decode (
    .req_type    (stage_req),
    .scan_code   (stage_code),
    .ext_pending (ext_pending),
    .dec         (dec)
  );

  sckm_matrix #(
    .MATRIX_ROWS (MATRIX_ROWS)
  ) u_matrix (
    .clk         (clk),
    .rst         (rst),
    .update      (advance),
    .row_select  (stage_sel),
    .dec         (dec),
    .ext_pending (ext_pending),
    .res         (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_word <= res_next;
    end
  end

  assign result.valid       = res_valid;
  assign result.row_index   = res_word.row_index;
  assign result.row_value   = res_word.row_value;
  assign result.row_changed = res_word.row_changed;
  assign result.hotkey      = res_word.hotkey;

endmodule

/* sim/scancode_to_key_matrix_top_tb.sv */
module scancode_to_key_matrix_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sckm_pkg::*;

  // The smallest row count that holds every row in the key table, so that rows 11 to 15 read as empty.
  localparam int N_ROWS = 11;
  localparam int PHASE_WORDS = 300;
  localparam int LOG_LIMIT = 60;

  typedef struct packed {
    logic                 req;
    logic [CODE_W-1:0]    code;
    logic [ROW_IDX_W-1:0] sel;
    logic                 given;
    res_t                 want;
  } stim_row_t;

  localparam res_t NO_RES = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sckm_in_if  request_if();
  sckm_out_if result_if();

  scancode_to_key_matrix_top #(.MATRIX_ROWS(N_ROWS)) u_top (
    .clk    (clk),
    .rst    (rst),
    .request(request_if),
    .result (result_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: its own key map, matrix rows and extended flag.
  logic [15:0]      key_map [256];
  logic [ROW_W-1:0] key_rows [16];
  logic             ext_armed;

  res_t      pending_rows [$];
  res_t      want_res;
  int        mismatches = 0;
  int        src_idle_pct = 37;
  int        snk_idle_pct = 45;
  stim_row_t plan [25];

  logic [CODE_W-1:0] ext_keys [14] = '{8'h1C, 8'h1D, 8'h35, 8'h38, 8'h3A, 8'h47, 8'h48,
                                       8'h4B, 8'h4D, 8'h50, 8'h52, 8'h53, 8'h70, 8'h4F};
  logic [CODE_W-1:0] hot_codes [8] = '{CODE_EXIT, CODE_LINE_UP, CODE_LINE_DOWN, CODE_REFRESH,
                                       CODE_DISK_B, CODE_DISK_A, CODE_TRACE, CODE_QUIET};

  initial begin
    key_map = '{default: 16'h0000};
    key_map[8'h01] = 16'h0704; key_map[8'h02] = 16'h0002; key_map[8'h03] = 16'h0004;
    key_map[8'h04] = 16'h0008; key_map[8'h05] = 16'h0010; key_map[8'h06] = 16'h0020;
    key_map[8'h07] = 16'h0040; key_map[8'h08] = 16'h0080; key_map[8'h09] = 16'h0101;
    key_map[8'h0A] = 16'h0102; key_map[8'h0B] = 16'h0001; key_map[8'h0C] = 16'h0104;
    key_map[8'h0D] = 16'h0108; key_map[8'h0E] = 16'h0720; key_map[8'h0F] = 16'h0708;
    key_map[8'h10] = 16'h0440; key_map[8'h11] = 16'h0510; key_map[8'h12] = 16'h0304;
    key_map[8'h13] = 16'h0480; key_map[8'h14] = 16'h0502; key_map[8'h15] = 16'h0540;
    key_map[8'h16] = 16'h0504; key_map[8'h17] = 16'h0340; key_map[8'h18] = 16'h0410;
    key_map[8'h19] = 16'h0420; key_map[8'h1A] = 16'h0120; key_map[8'h1B] = 16'h0140;
    key_map[8'h1C] = 16'h0780; key_map[8'h1D] = 16'h0602; key_map[8'h1E] = 16'h0240;
    key_map[8'h1F] = 16'h0501; key_map[8'h20] = 16'h0302; key_map[8'h21] = 16'h0308;
    key_map[8'h22] = 16'h0310; key_map[8'h23] = 16'h0320; key_map[8'h24] = 16'h0380;
    key_map[8'h25] = 16'h0401; key_map[8'h26] = 16'h0402; key_map[8'h27] = 16'h0180;
    key_map[8'h28] = 16'h0201; key_map[8'h29] = 16'h0704; key_map[8'h2A] = 16'h0601;
    key_map[8'h2B] = 16'h0202; key_map[8'h2C] = 16'h0580; key_map[8'h2D] = 16'h0520;
    key_map[8'h2E] = 16'h0301; key_map[8'h2F] = 16'h0508; key_map[8'h30] = 16'h0280;
    key_map[8'h31] = 16'h0408; key_map[8'h32] = 16'h0404; key_map[8'h33] = 16'h0204;
    key_map[8'h34] = 16'h0208; key_map[8'h35] = 16'h0210; key_map[8'h36] = 16'h0601;
    key_map[8'h37] = 16'h0901; key_map[8'h38] = 16'h0604; key_map[8'h39] = 16'h0801;
    key_map[8'h3A] = 16'h0608; key_map[8'h3B] = 16'h0620; key_map[8'h3C] = 16'h0640;
    key_map[8'h3D] = 16'h0680; key_map[8'h3E] = 16'h0701; key_map[8'h3F] = 16'h0702;
    key_map[8'h47] = 16'h0A04; key_map[8'h48] = 16'h0A08; key_map[8'h49] = 16'h0A10;
    key_map[8'h4A] = 16'h0A20; key_map[8'h4B] = 16'h0980; key_map[8'h4C] = 16'h0A01;
    key_map[8'h4D] = 16'h0A02; key_map[8'h4E] = 16'h0902; key_map[8'h4F] = 16'h0910;
    key_map[8'h50] = 16'h0920; key_map[8'h51] = 16'h0940; key_map[8'h52] = 16'h0908;
    key_map[8'h53] = 16'h0A80; key_map[8'h57] = 16'h0740; key_map[8'h58] = 16'h0710;
    key_map[8'h70] = 16'h0610; key_map[8'h73] = 16'h0220; key_map[8'h7D] = 16'h0110;
    key_map[8'h9C] = 16'h0780; key_map[8'h9D] = 16'h0610; key_map[8'hB5] = 16'h0210;
    key_map[8'hB8] = 16'h0740; key_map[8'hBA] = 16'h0608; key_map[8'hC7] = 16'h0802;
    key_map[8'hC8] = 16'h0820; key_map[8'hCB] = 16'h0810; key_map[8'hCD] = 16'h0880;
    key_map[8'hD0] = 16'h0840; key_map[8'hD2] = 16'h0804; key_map[8'hD3] = 16'h0808;
    key_map[8'hF0] = 16'h0610;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < LOG_LIMIT)
      $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic [HOT_W-1:0] hotkey_for(input logic [CODE_W-1:0] code,
                                                  input logic ext);
    if (ext && code == CODE_EXIT) return HOT_EXIT;
    if (ext && code == CODE_LINE_UP) return HOT_LINE_UP;
    if (ext && code == CODE_LINE_DOWN) return HOT_LINE_DOWN;
    case (code)
      CODE_REFRESH: return HOT_REFRESH;
      CODE_DISK_B:  return HOT_DISK_B;
      CODE_DISK_A:  return HOT_DISK_A;
      CODE_TRACE:   return HOT_TRACE;
      CODE_QUIET:   return HOT_QUIET;
      default:      return HOT_NONE;
    endcase
  endfunction

  // Applies one word to the predicted matrix and returns the row it reports.
  function automatic res_t apply_key_word(input logic req, input logic [CODE_W-1:0] code,
                                          input logic [ROW_IDX_W-1:0] sel);
    res_t                 r;
    logic [15:0]          ent;
    logic [ROW_IDX_W-1:0] row;
    r = '0;
    if (req == REQ_READ) begin
      r.row_index = sel;
      r.row_value = (sel < N_ROWS) ? key_rows[sel] : 8'hFF;
    end else if (code == CODE_PREFIX_EXT) begin
      ext_armed = 1'b1;
    end else begin
      r.hotkey = hotkey_for(code, ext_armed);
      if (r.hotkey == HOT_NONE) begin
        ent = key_map[{ext_armed, code[6:0]}];
        row = ent[11:8];
        r.row_index = row;
        if (row < N_ROWS) begin
          if (code[7])
            key_rows[row] = key_rows[row] | ent[7:0];
          else
            key_rows[row] = key_rows[row] & ~ent[7:0];
          r.row_value = key_rows[row];
          r.row_changed = 1'b1;
        end else begin
          r.row_value = 8'hFF;
        end
        ext_armed = 1'b0;
      end
    end
    return r;
  endfunction

  task automatic send_word(input logic req, input logic [CODE_W-1:0] code,
                           input logic [ROW_IDX_W-1:0] sel, input logic given,
                           input res_t want);
    res_t p;
    while ($urandom_range(99) < src_idle_pct) begin
      request_if.valid <= 1'b0;
      @(posedge clk);
    end
    request_if.valid      <= 1'b1;
    request_if.req_type   <= req;
    request_if.scan_code  <= code;
    request_if.row_select <= sel;
    @(posedge clk);
    while (!request_if.ready) @(posedge clk);
    p = apply_key_word(req, code, sel);
    pending_rows.push_back(given ? want : p);
  endtask

  task automatic send_scan(input logic [CODE_W-1:0] code);
    send_word(REQ_SCAN, code, ROW_IDX_W'($urandom_range(15)), 1'b0, NO_RES);
  endtask

  // Holds the request side low until every outstanding word has returned.
  task automatic drain_results();
    request_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_rows.size() != 0) @(posedge clk);
  endtask

  // One random burst; a prefix is mostly followed by an extended key. Returns words sent.
  task automatic send_random_burst(output int sent);
    int                pick;
    logic [CODE_W-1:0] code;
    pick = $urandom_range(99);
    sent = 1;
    if (pick < 20) begin
      send_word(REQ_READ, CODE_W'($urandom), ROW_IDX_W'($urandom_range(15)), 1'b0, NO_RES);
    end else if (pick < 40) begin
      send_scan(CODE_PREFIX_EXT);
      if ($urandom_range(3) == 0) begin
        send_scan(hot_codes[$urandom_range(7)]);
        sent++;
      end
      code = ext_keys[$urandom_range(13)];
      code[7] = 1'($urandom_range(1));
      send_scan(code);
      sent++;
    end else if (pick < 75) begin
      code = CODE_W'($urandom_range(8'h01, 8'h58));
      code[7] = 1'($urandom_range(1));
      send_scan(code);
    end else if (pick < 85) begin
      send_scan(hot_codes[$urandom_range(7)]);
    end else begin
      send_scan(CODE_W'($urandom));
    end
  endtask

  always @(posedge clk)
    result_if.ready <= ($urandom_range(99) >= snk_idle_pct);

  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_rows.size() == 0) begin
        report_mismatch($sformatf("result word with nothing pending: row %0d value %02h",
                                  result_if.row_index, result_if.row_value));
      end else begin
        want_res = pending_rows.pop_front();
        if (result_if.row_index !== want_res.row_index)
          report_mismatch($sformatf("row_index %0d, want %0d",
                                    result_if.row_index, want_res.row_index));
        if (result_if.row_value !== want_res.row_value)
          report_mismatch($sformatf("row_value %02h, want %02h (row %0d)",
                                    result_if.row_value, want_res.row_value,
                                    want_res.row_index));
        if (result_if.row_changed !== want_res.row_changed)
          report_mismatch($sformatf("row_changed %0b, want %0b",
                                    result_if.row_changed, want_res.row_changed));
        if (result_if.hotkey !== want_res.hotkey)
          report_mismatch($sformatf("hotkey %0d, want %0d",
                                    result_if.hotkey, want_res.hotkey));
      end
    end
  end

  initial begin
    int sent;
    int count;
    request_if.valid      = 1'b0;
    request_if.req_type   = REQ_SCAN;
    request_if.scan_code  = '0;
    request_if.row_select = '0;
    result_if.ready       = 1'b0;
    for (int i = 0; i < 16; i++) key_rows[i] = 8'hFF;
    ext_armed = 1'b0;

    // Rows with a given result are plain: untouched rows, beyond the matrix,
    // prefix and hotkeys. The rest follow the predictor.
    plan = '{
      '{REQ_READ, 8'hA5, 4'd0, 1'b1, '{4'd0, 8'hFF, 1'b0, HOT_NONE}},
      '{REQ_READ, 8'h5A, 4'd15, 1'b1, '{4'd15, 8'hFF, 1'b0, HOT_NONE}},
      '{REQ_SCAN, 8'h00, 4'd0, 1'b0, NO_RES},           // empty entry lands on row 0
      '{REQ_SCAN, 8'h02, 4'd15, 1'b0, NO_RES},
      '{REQ_SCAN, 8'h82, 4'd3, 1'b0, NO_RES},
      '{REQ_SCAN, 8'hFF, 4'd9, 1'b0, NO_RES},
      '{REQ_SCAN, CODE_PREFIX_EXT, 4'd0, 1'b1, NO_RES},
      '{REQ_SCAN, CODE_EXIT, 4'd1, 1'b1, '{4'd0, 8'h00, 1'b0, HOT_EXIT}},
      '{REQ_SCAN, CODE_LINE_UP, 4'd2, 1'b1, '{4'd0, 8'h00, 1'b0, HOT_LINE_UP}},
      '{REQ_SCAN, CODE_LINE_DOWN, 4'd4, 1'b1, '{4'd0, 8'h00, 1'b0, HOT_LINE_DOWN}},
      '{REQ_SCAN, CODE_REFRESH, 4'd8, 1'b1, '{4'd0, 8'h00, 1'b0, HOT_REFRESH}},
      '{REQ_SCAN, CODE_DISK_B, 4'd7, 1'b1, '{4'd0, 8'h00, 1'b0, HOT_DISK_B}},
      '{REQ_SCAN, CODE_DISK_A, 4'd11, 1'b1, '{4'd0, 8'h00, 1'b0, HOT_DISK_A}},
      '{REQ_SCAN, CODE_TRACE, 4'd13, 1'b1, '{4'd0, 8'h00, 1'b0, HOT_TRACE}},
      '{REQ_SCAN, CODE_QUIET, 4'd14, 1'b1, '{4'd0, 8'h00, 1'b0, HOT_QUIET}},
      '{REQ_SCAN, 8'h1C, 4'd0, 1'b0, NO_RES},           // flag still armed after hotkeys
      '{REQ_SCAN, CODE_EXIT, 4'd0, 1'b0, NO_RES},       // plain lookup without the flag
      '{REQ_SCAN, CODE_LINE_UP, 4'd0, 1'b0, NO_RES},
      '{REQ_SCAN, CODE_LINE_DOWN, 4'd0, 1'b0, NO_RES},
      '{REQ_SCAN, CODE_PREFIX_EXT, 4'd0, 1'b1, NO_RES},
      '{REQ_SCAN, CODE_PREFIX_EXT, 4'd0, 1'b1, NO_RES},
      '{REQ_SCAN, 8'hC7, 4'd0, 1'b0, NO_RES},
      '{REQ_SCAN, CODE_PREFIX_EXT, 4'd0, 1'b1, NO_RES},
      '{REQ_READ, 8'hFF, 4'd8, 1'b0, NO_RES},           // a read keeps the flag armed
      '{REQ_SCAN, 8'h48, 4'd0, 1'b0, NO_RES}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i])
      send_word(plan[i].req, plan[i].code, plan[i].sel, plan[i].given, plan[i].want);
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin src_idle_pct = 37; snk_idle_pct = 45; end
        1: begin src_idle_pct = 45; snk_idle_pct = 37; end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      count = 0;
      while (count < PHASE_WORDS) begin
        send_random_burst(sent);
        count += sent;
        if (count >= PHASE_WORDS / 2 && count - sent < PHASE_WORDS / 2)
          drain_results();
      end
    end
    request_if.valid <= 1'b0;

    while (pending_rows.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("scancode_to_key_matrix_top: match");
    else
      $display("scancode_to_key_matrix_top: mismatch");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("scancode_to_key_matrix_top: mismatch");
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/sckm_pkg.sv
sv/sckm_in_if.sv
sv/sckm_out_if.sv
sv/sckm_decode.sv
sv/sckm_matrix.sv
sv/scancode_to_key_matrix_top.sv
sim/scancode_to_key_matrix_top_tb.sv
